// ===== rtl/core/cylinder_mesh_element_generator_macros.svh =====
// ----------------------------------------------------------------------------
// Cylinder mesh element generator - assertion macros
// Shared concurrent assertion forms. All of them are clocked on clk and
// switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CYLINDER_MESH_ELEMENT_GENERATOR_MACROS_SVH
`define CYLINDER_MESH_ELEMENT_GENERATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CMEG_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CMEG_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cmeg_pkg.sv =====
// ----------------------------------------------------------------------------
// Cylinder mesh element generator - shared package
// Widths, codes, the request side-band type and the arithmetic helpers that
// the pipeline modules share.
// ----------------------------------------------------------------------------
package cmeg_pkg;

    localparam int NW                  = 11;  // sector count width
    localparam int IW                  = 13;  // item and vertex index width
    localparam int AW                  = 14;  // index arithmetic width
    localparam int PHASE_BITS          = 32;  // angle in turns, Q0.32
    localparam int S_BITS              = 14;  // side texture quotient bits
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES          = PHASE_BITS / DIV_STEPS_PER_STAGE;
    localparam int ANG_W               = 33;  // signed Q30 datapath width
    localparam int ATAN_LEN            = 24;
    localparam int ANG_PROD_W          = 61;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic signed [ANG_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

    localparam logic [30:0] ATAN_Q30 [ATAN_LEN] = '{
        31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158,
        31'd67021686,  31'd33543515,  31'd16775850,  31'd8388437,
        31'd4194282,   31'd2097149,   31'd1048575,   31'd524287,
        31'd262143,    31'd131071,    31'd65535,     31'd32767,
        31'd16383,     31'd8191,      31'd4095,      31'd2047,
        31'd1023,      31'd511,       31'd255,       31'd127
    };

    typedef enum logic {
        OP_VERTEX   = 1'b0,
        OP_TRIANGLE = 1'b1
    } cmeg_op_t;

    typedef enum logic [1:0] {
        REG_SECTOR_COUNT = 2'd0,
        REG_CYL_HEIGHT   = 2'd1,
        REG_CYL_RADIUS   = 2'd2
    } cmeg_reg_t;

    // Side-band that travels with each request through the pipeline.
    typedef struct packed {
        logic          is_tri;
        logic          bad;
        logic          is_side;
        logic          is_center;
        logic          upper;
        logic          s_full;
        logic [1:0]    quad;
        logic [14:0]   s_val;
        logic [IW-1:0] cor_a;
        logic [IW-1:0] cor_b;
        logic [IW-1:0] cor_c;
    } cmeg_meta_t;

    // One restoring division step: returns {quotient bit, new remainder}.
    function automatic logic [NW:0] cmeg_div_step(input logic [NW-1:0] rem,
                                                  input logic bit_in,
                                                  input logic [NW-1:0] dvs);
        logic [NW:0] trial;
        logic [NW:0] result;
        trial = {rem, bit_in};
        if (trial >= {1'b0, dvs})
        begin
            result = {1'b1, NW'(trial - {1'b0, dvs})};
        end
        else
        begin
            result = {1'b0, trial[NW-1:0]};
        end
        return result;
    endfunction

endpackage

// ===== rtl/core/cylinder_mesh_element_generator.sv =====
// ----------------------------------------------------------------------------
// Cylinder mesh element generator - top level
// Answers one request per cycle, while no result is stalled, for a single vertex or
// triangle of a smooth cylinder mesh with a configurable number of sectors, height and radius.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  -------   ---------------------  -----------------------------------------
//  request   in_valid / in_ready    operation, item_number
//  result    out_valid / out_ready  pos_*, norm_*, tex_*, corner_*, status
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  A new request can enter in every cycle while no result is stalled; each one
//  passes the request and classify stages, the 16-stage phase divider, the angle
//  stage, the one-rotation-per-stage CORDIC and the quadrant, product and output stages.
//  The pipeline moves as one: it advances whenever the output register is
//  empty or being taken, and holds every stage while a result is stalled.
//  Reset clears the stage valid bits and loads the register defaults
//  (36 sectors, height and radius 1.0).
//  Configuration writes are always taken.
// ----------------------------------------------------------------------------
`include "cylinder_mesh_element_generator_macros.svh"

module cylinder_mesh_element_generator
    import cmeg_pkg::*;
#(
    parameter int MAX_SECTORS  = 1024,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    // Request channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic [12:0]        item_number,
    // Result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] pos_x,
    output logic signed [15:0] pos_y,
    output logic signed [15:0] pos_z,
    output logic signed [15:0] norm_x,
    output logic signed [15:0] norm_y,
    output logic signed [15:0] norm_z,
    output logic [14:0]        tex_s,
    output logic [14:0]        tex_t,
    output logic [12:0]        corner_a,
    output logic [12:0]        corner_b,
    output logic [12:0]        corner_c,
    output logic               status,
    // Configuration channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [14:0]        cfg_data
);

    // ------------------------------------------------------------------
    // Helpers for the final fixed-point conversions.
    // ------------------------------------------------------------------

    // Q30 to Q1.14, rounded half up and saturated to plus or minus one.
    function automatic logic signed [15:0] to_q14(input logic signed [ANG_W-1:0] v);
        logic signed [ANG_W:0] sum;
        logic signed [17:0]    sh;
        logic signed [15:0]    r;
        sum = (ANG_W+1)'(v) + 34'sd32768;
        sh  = 18'(sum >>> 16);
        if (sh > 18'sd16384)
        begin
            r = 16'sd16384;
        end
        else if (sh < -18'sd16384)
        begin
            r = -16'sd16384;
        end
        else
        begin
            r = 16'(sh);
        end
        return r;
    endfunction

    // (1 - u) / 2 from Q30 to Q1.14, saturated to the range zero to one.
    function automatic logic [14:0] to_tex(input logic signed [ANG_W-1:0] v);
        logic signed [ANG_W+1:0] sum;
        logic signed [18:0]      sh;
        logic [14:0]             r;
        sum = 35'sd1073741824 - (ANG_W+2)'(v) + 35'sd65536;
        sh  = 19'(sum >>> 17);
        if (sh > 19'sd16384)
        begin
            r = 15'd16384;
        end
        else if (sh < 19'sd0)
        begin
            r = '0;
        end
        else
        begin
            r = 15'(sh);
        end
        return r;
    endfunction

    // Q30 times Q8.8 radius back to Q8.8, rounded and saturated to 16 bits.
    function automatic logic signed [15:0] to_pos(input logic signed [47:0] p);
        logic signed [48:0] sum;
        logic signed [18:0] sh;
        logic signed [15:0] r;
        sum = 49'(p) + 49'sd536870912;
        sh  = 19'(sum >>> 30);
        if (sh > 19'sd32767)
        begin
            r = 16'sd32767;
        end
        else if (sh < -19'sd32768)
        begin
            r = -16'sd32768;
        end
        else
        begin
            r = 16'(sh);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers. Writes are registered; an index past
    // the register list is accepted and dropped.
    // ------------------------------------------------------------------
    logic [NW-1:0] count_reg;
    logic [14:0]   height_reg;
    logic [14:0]   radius_reg;
    logic [NW-1:0] n_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 11'd36;
            height_reg <= 15'd256;
            radius_reg <= 15'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SECTOR_COUNT: count_reg  <= cfg_data[NW-1:0];
                REG_CYL_HEIGHT:   height_reg <= cfg_data;
                REG_CYL_RADIUS:   radius_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // The sector count in use is clamped to 3 .. MAX_SECTORS.
    always_comb
    begin
        if (count_reg < 11'd3)
        begin
            n_eff = 11'd3;
        end
        else if (32'(count_reg) > MAX_SECTORS)
        begin
            n_eff = 11'(MAX_SECTORS);
        end
        else
        begin
            n_eff = count_reg;
        end
    end

    // ------------------------------------------------------------------
    // Global pipeline enable. Every stage moves together whenever the
    // output register is free or its result is being taken this cycle.
    // ------------------------------------------------------------------
    logic en;
    logic out_valid_reg;
    logic out_tri_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // ------------------------------------------------------------------
    // Stage 1: request register.
    // ------------------------------------------------------------------
    logic          s1_valid_reg;
    logic          s1_op_reg;
    logic [IW-1:0] s1_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg   <= operation;
            s1_item_reg <= item_number;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: classify the request. Vertex requests are split into side,
    // cap center and cap rim, with the sector index j they use; triangle
    // requests get their three corner indices here directly.
    // ------------------------------------------------------------------
    cmeg_meta_t    cls_meta;
    logic [NW-1:0] cls_j;
    logic          s2_valid_reg;
    cmeg_meta_t    s2_meta_reg;
    logic [NW-1:0] s2_j_reg;

    always_comb
    begin
        logic [AW-1:0] n_w;
        logic [AW-1:0] it_w;
        logic [AW-1:0] np1;
        logic [AW-1:0] n2;
        logic [AW-1:0] n3;
        logic [AW-1:0] c_off;
        logic [AW-1:0] p_off;
        logic [AW-1:0] j_w;
        logic [AW-1:0] k1;
        logic [AW-1:0] k2;
        logic [AW-1:0] ctr;
        logic [AW-1:0] tri_i;
        logic [AW-1:0] rim_r;
        n_w   = AW'(n_eff);
        it_w  = AW'(s1_item_reg);
        np1   = n_w + AW'(1);
        n2    = n_w << 1;
        n3    = n2 + n_w;
        c_off = it_w - (n2 + AW'(2));
        p_off = '0;
        j_w   = '0;
        k1    = it_w >> 1;
        k2    = np1 + k1;
        ctr   = '0;
        tri_i = '0;
        rim_r = '0;
        cls_meta = '0;
        if (s1_op_reg == OP_VERTEX)
        begin
            if (it_w >= (n_w << 2) + AW'(4))
            begin
                cls_meta.bad = 1'b1;
            end
            else if (it_w < n2 + AW'(2))
            begin
                cls_meta.is_side = 1'b1;
                cls_meta.upper   = (it_w >= np1);
                j_w = cls_meta.upper ? it_w - np1 : it_w;
            end
            else
            begin
                cls_meta.upper     = (c_off >= np1);
                p_off              = cls_meta.upper ? c_off - np1 : c_off;
                cls_meta.is_center = (p_off == '0);
                j_w = cls_meta.is_center ? '0 : p_off - AW'(1);
            end
        end
        else
        begin
            cls_meta.is_tri = 1'b1;
            if (it_w >= (n_w << 2))
            begin
                cls_meta.bad = 1'b1;
            end
            else if (it_w < n2)
            begin
                // Two side triangles per sector, between the two rings.
                if (!it_w[0])
                begin
                    cls_meta.cor_a = IW'(k1);
                    cls_meta.cor_b = IW'(k1 + AW'(1));
                    cls_meta.cor_c = IW'(k2);
                end
                else
                begin
                    cls_meta.cor_a = IW'(k2);
                    cls_meta.cor_b = IW'(k1 + AW'(1));
                    cls_meta.cor_c = IW'(k2 + AW'(1));
                end
            end
            else if (it_w < n3)
            begin
                // Base fan; the last triangle closes on the first rim vertex.
                tri_i = it_w - n2;
                ctr   = n2 + AW'(2);
                rim_r = ctr + AW'(1) + tri_i;
                cls_meta.cor_a = IW'(ctr);
                cls_meta.cor_b = IW'((tri_i + AW'(1) < n_w) ? rim_r + AW'(1)
                                                            : ctr + AW'(1));
                cls_meta.cor_c = IW'(rim_r);
            end
            else
            begin
                // Top fan, wound the other way round.
                tri_i = it_w - n3;
                ctr   = n3 + AW'(3);
                rim_r = ctr + AW'(1) + tri_i;
                cls_meta.cor_a = IW'(ctr);
                cls_meta.cor_b = IW'(rim_r);
                cls_meta.cor_c = IW'((tri_i + AW'(1) < n_w) ? rim_r + AW'(1)
                                                            : ctr + AW'(1));
            end
        end
        // The angle of j = n wraps to zero; only the side s keeps the full turn.
        cls_meta.s_full = (j_w == n_w);
        cls_j = cls_meta.s_full ? '0 : j_w[NW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_meta_reg <= cls_meta;
            s2_j_reg    <= cls_j;
        end
    end

    // ------------------------------------------------------------------
    // Phase divider: j/n of a full turn, plus the side texture s.
    // ------------------------------------------------------------------
    logic                  dv_valid;
    cmeg_meta_t            dv_meta;
    logic [PHASE_BITS-1:0] dv_phase;

    cmeg_phase_div u_phase_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .in_meta   (s2_meta_reg),
        .in_j      (s2_j_reg),
        .sectors   (n_eff),
        .out_valid (dv_valid),
        .out_meta  (dv_meta),
        .out_phase (dv_phase)
    );

    // ------------------------------------------------------------------
    // Stage 3: the top two phase bits pick the quadrant; the rest is
    // scaled by pi/2 into a Q30 angle in radians, rounded.
    // ------------------------------------------------------------------
    logic [ANG_PROD_W-1:0]   ang_prod;
    logic [ANG_PROD_W-1:0]   ang_round;
    cmeg_meta_t              ang_meta;
    logic                    s3_valid_reg;
    cmeg_meta_t              s3_meta_reg;
    logic signed [ANG_W-1:0] s3_z_reg;

    assign ang_prod  = ANG_PROD_W'(dv_phase[29:0]) * ANG_PROD_W'(HALF_PI_Q30);
    assign ang_round = ang_prod + (ANG_PROD_W'(1) << 29);

    always_comb
    begin
        ang_meta      = dv_meta;
        ang_meta.quad = dv_phase[PHASE_BITS-1:PHASE_BITS-2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_meta_reg <= ang_meta;
            s3_z_reg    <= $signed({2'b00, ang_round[60:30]});
        end
    end

    // ------------------------------------------------------------------
    // CORDIC rotation.
    // ------------------------------------------------------------------
    logic                    cr_valid;
    cmeg_meta_t              cr_meta;
    logic signed [ANG_W-1:0] cr_x;
    logic signed [ANG_W-1:0] cr_y;

    cmeg_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .in_meta   (s3_meta_reg),
        .in_z      (s3_z_reg),
        .out_valid (cr_valid),
        .out_meta  (cr_meta),
        .out_x     (cr_x),
        .out_y     (cr_y)
    );

    // ------------------------------------------------------------------
    // Stage 4: map the first-quadrant result back to its quadrant.
    // ------------------------------------------------------------------
    logic signed [ANG_W-1:0] quad_cx;
    logic signed [ANG_W-1:0] quad_sy;
    logic                    s4_valid_reg;
    cmeg_meta_t              s4_meta_reg;
    logic signed [ANG_W-1:0] s4_cx_reg;
    logic signed [ANG_W-1:0] s4_sy_reg;

    always_comb
    begin
        unique case (cr_meta.quad)
            2'd0:
            begin
                quad_cx = cr_x;
                quad_sy = cr_y;
            end
            2'd1:
            begin
                quad_cx = -cr_y;
                quad_sy = cr_x;
            end
            2'd2:
            begin
                quad_cx = -cr_x;
                quad_sy = -cr_y;
            end
            default:
            begin
                quad_cx = cr_y;
                quad_sy = -cr_x;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg <= cr_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_meta_reg <= cr_meta;
            s4_cx_reg   <= quad_cx;
            s4_sy_reg   <= quad_sy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: radius products, normals and cap texture coordinates.
    // ------------------------------------------------------------------
    logic signed [47:0] prod_x;
    logic signed [47:0] prod_y;
    logic               s5_valid_reg;
    cmeg_meta_t         s5_meta_reg;
    logic signed [47:0] s5_px_reg;
    logic signed [47:0] s5_py_reg;
    logic signed [15:0] s5_nx_reg;
    logic signed [15:0] s5_ny_reg;
    logic [14:0]        s5_tx_reg;
    logic [14:0]        s5_ty_reg;

    assign prod_x = s4_cx_reg * $signed({1'b0, radius_reg});
    assign prod_y = s4_sy_reg * $signed({1'b0, radius_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_meta_reg <= s4_meta_reg;
            s5_px_reg   <= prod_x;
            s5_py_reg   <= prod_y;
            s5_nx_reg   <= to_q14(s4_cx_reg);
            s5_ny_reg   <= to_q14(s4_sy_reg);
            s5_tx_reg   <= to_tex(s4_cx_reg);
            s5_ty_reg   <= to_tex(s4_sy_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: assemble the result into the output register. Fields that
    // do not belong to the request kind are forced to zero, and an out of
    // range request returns only the status flag.
    // ------------------------------------------------------------------
    logic signed [15:0] z_half;
    logic signed [15:0] z_side;
    logic signed [15:0] pos_x_next;
    logic signed [15:0] pos_y_next;
    logic signed [15:0] pos_z_next;
    logic signed [15:0] norm_x_next;
    logic signed [15:0] norm_y_next;
    logic signed [15:0] norm_z_next;
    logic [14:0]        tex_s_next;
    logic [14:0]        tex_t_next;
    logic [IW-1:0]      corner_a_next;
    logic [IW-1:0]      corner_b_next;
    logic [IW-1:0]      corner_c_next;
    logic               status_next;
    logic signed [15:0] pos_x_reg;
    logic signed [15:0] pos_y_reg;
    logic signed [15:0] pos_z_reg;
    logic signed [15:0] norm_x_reg;
    logic signed [15:0] norm_y_reg;
    logic signed [15:0] norm_z_reg;
    logic [14:0]        tex_s_reg;
    logic [14:0]        tex_t_reg;
    logic [IW-1:0]      corner_a_reg;
    logic [IW-1:0]      corner_b_reg;
    logic [IW-1:0]      corner_c_reg;
    logic               status_reg;

    // Half height, with halves rounded away from zero.
    assign z_half = $signed(16'(({1'b0, height_reg} + 16'd1) >> 1));
    assign z_side = s5_meta_reg.upper ? z_half : -z_half;

    always_comb
    begin
        pos_x_next    = '0;
        pos_y_next    = '0;
        pos_z_next    = '0;
        norm_x_next   = '0;
        norm_y_next   = '0;
        norm_z_next   = '0;
        tex_s_next    = '0;
        tex_t_next    = '0;
        corner_a_next = '0;
        corner_b_next = '0;
        corner_c_next = '0;
        status_next   = 1'b0;
        priority if (s5_meta_reg.bad)
        begin
            status_next = 1'b1;
        end
        else if (s5_meta_reg.is_tri)
        begin
            corner_a_next = s5_meta_reg.cor_a;
            corner_b_next = s5_meta_reg.cor_b;
            corner_c_next = s5_meta_reg.cor_c;
        end
        else if (s5_meta_reg.is_side)
        begin
            pos_x_next  = to_pos(s5_px_reg);
            pos_y_next  = to_pos(s5_py_reg);
            pos_z_next  = z_side;
            norm_x_next = s5_nx_reg;
            norm_y_next = s5_ny_reg;
            tex_s_next  = s5_meta_reg.s_full ? 15'd16384 : s5_meta_reg.s_val;
            tex_t_next  = s5_meta_reg.upper ? 15'd0 : 15'd16384;
        end
        else if (s5_meta_reg.is_center)
        begin
            pos_z_next  = z_side;
            norm_z_next = s5_meta_reg.upper ? 16'sd16384 : -16'sd16384;
            tex_s_next  = 15'd8192;
            tex_t_next  = 15'd8192;
        end
        else
        begin
            pos_x_next  = to_pos(s5_px_reg);
            pos_y_next  = to_pos(s5_py_reg);
            pos_z_next  = z_side;
            norm_z_next = s5_meta_reg.upper ? 16'sd16384 : -16'sd16384;
            tex_s_next  = s5_tx_reg;
            tex_t_next  = s5_ty_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            pos_z_reg    <= pos_z_next;
            norm_x_reg   <= norm_x_next;
            norm_y_reg   <= norm_y_next;
            norm_z_reg   <= norm_z_next;
            tex_s_reg    <= tex_s_next;
            tex_t_reg    <= tex_t_next;
            corner_a_reg <= corner_a_next;
            corner_b_reg <= corner_b_next;
            corner_c_reg <= corner_c_next;
            status_reg   <= status_next;
            out_tri_reg  <= s5_meta_reg.is_tri;
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_z     = pos_z_reg;
    assign norm_x    = norm_x_reg;
    assign norm_y    = norm_y_reg;
    assign norm_z    = norm_z_reg;
    assign tex_s     = tex_s_reg;
    assign tex_t     = tex_t_reg;
    assign corner_a  = corner_a_reg;
    assign corner_b  = corner_b_reg;
    assign corner_c  = corner_c_reg;
    assign status    = status_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    logic bad_fields_zero;
    logic vertex_fields_zero;
    logic corners_zero;

    assign bad_fields_zero    = pos_x == '0 && pos_z == '0 && norm_z == '0 && tex_s == '0
                                && corner_a == '0 && corner_c == '0;
    assign vertex_fields_zero = pos_x == '0 && pos_y == '0 && pos_z == '0 && norm_z == '0
                                && tex_t == '0;
    assign corners_zero       = corner_a == '0 && corner_b == '0 && corner_c == '0;

    `CMEG_ASSERT_IMPL(a_bad_result_clean, out_valid && status, bad_fields_zero, "bad result data")
    `CMEG_ASSERT_IMPL(a_tri_no_vertex, out_valid && out_tri_reg, vertex_fields_zero, "tri data")
    `CMEG_ASSERT_IMPL(a_vertex_no_corner, out_valid && !out_tri_reg, corners_zero, "corners set")
    `CMEG_ASSERT_IMPL(a_stall_blocks_input, out_valid && !out_ready, !in_ready, "taken in stall")
    `CMEG_ASSERT_NEXT(a_last_stage_lands, s5_valid_reg && en, out_valid, "result lost")

endmodule

// ===== rtl/core/cmeg_phase_div.sv =====
// ----------------------------------------------------------------------------
// Cylinder mesh element generator - sector phase divider
// Pipelined restoring divider. Computes round(j * 2^32 / n) and
// round(j * 2^14 / n), two quotient bits per stage.
// ----------------------------------------------------------------------------
module cmeg_phase_div
    import cmeg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  cmeg_meta_t            in_meta,
    input  logic [NW-1:0]         in_j,
    input  logic [NW-1:0]         sectors,
    output logic                  out_valid,
    output cmeg_meta_t            out_meta,
    output logic [PHASE_BITS-1:0] out_phase
);

    logic [DIV_STAGES-1:0]   valid_reg;
    cmeg_meta_t              meta_reg   [DIV_STAGES];
    logic [NW-1:0]           rem_p_reg  [DIV_STAGES];
    logic [NW-1:0]           rem_p_next [DIV_STAGES];
    logic [PHASE_BITS-1:0]   q_p_reg    [DIV_STAGES];
    logic [PHASE_BITS-1:0]   q_p_next   [DIV_STAGES];
    logic [NW-1:0]           rem_s_reg  [DIV_STAGES];
    logic [NW-1:0]           rem_s_next [DIV_STAGES];
    logic [S_BITS-1:0]       q_s_reg    [DIV_STAGES];
    logic [S_BITS-1:0]       q_s_next   [DIV_STAGES];
    logic [PHASE_BITS-1:0]   half_p;
    logic [S_BITS-1:0]       half_s;

    // The rounding term n/2 sits in the low bits of both numerators.
    assign half_p = PHASE_BITS'(sectors >> 1);
    assign half_s = S_BITS'(sectors >> 1);

    always_comb
    begin
        int            st;
        logic [NW:0]   step;
        logic [NW-1:0] rp;
        logic [NW-1:0] rs;
        logic [PHASE_BITS-1:0] qp;
        logic [S_BITS-1:0]     qs;
        st   = 0;
        step = '0;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (k == 0)
            begin
                rp = in_j;
                rs = in_j;
                qp = '0;
                qs = '0;
            end
            else
            begin
                rp = rem_p_reg[k-1];
                rs = rem_s_reg[k-1];
                qp = q_p_reg[k-1];
                qs = q_s_reg[k-1];
            end
            for (int b = 0; b < DIV_STEPS_PER_STAGE; b++)
            begin
                st   = k * DIV_STEPS_PER_STAGE + b;
                step = cmeg_div_step(rp, half_p[PHASE_BITS-1-st], sectors);
                rp   = step[NW-1:0];
                qp   = {qp[PHASE_BITS-2:0], step[NW]};
                if (st < S_BITS)
                begin
                    step = cmeg_div_step(rs, half_s[S_BITS-1-st], sectors);
                    rs   = step[NW-1:0];
                    qs   = {qs[S_BITS-2:0], step[NW]};
                end
            end
            rem_p_next[k] = rp;
            rem_s_next[k] = rs;
            q_p_next[k]   = qp;
            q_s_next[k]   = qs;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                meta_reg[k]  <= (k == 0) ? in_meta : meta_reg[k == 0 ? 0 : k-1];
                rem_p_reg[k] <= rem_p_next[k];
                rem_s_reg[k] <= rem_s_next[k];
                q_p_reg[k]   <= q_p_next[k];
                q_s_reg[k]   <= q_s_next[k];
            end
        end
    end

    always_comb
    begin
        out_meta       = meta_reg[DIV_STAGES-1];
        out_meta.s_val = 15'(q_s_reg[DIV_STAGES-1]);
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_phase = q_p_reg[DIV_STAGES-1];

endmodule

// ===== rtl/core/cmeg_cordic.sv =====
// ----------------------------------------------------------------------------
// Cylinder mesh element generator - rotation CORDIC
// One micro-rotation per stage from (K, 0), giving cosine and sine in Q30.
// ----------------------------------------------------------------------------
module cmeg_cordic
    import cmeg_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  cmeg_meta_t              in_meta,
    input  logic signed [ANG_W-1:0] in_z,
    output logic                    out_valid,
    output cmeg_meta_t              out_meta,
    output logic signed [ANG_W-1:0] out_x,
    output logic signed [ANG_W-1:0] out_y
);

    logic [STEPS-1:0]        valid_reg;
    cmeg_meta_t              meta_reg [STEPS];
    logic signed [ANG_W-1:0] x_reg    [STEPS];
    logic signed [ANG_W-1:0] x_next   [STEPS];
    logic signed [ANG_W-1:0] y_reg    [STEPS];
    logic signed [ANG_W-1:0] y_next   [STEPS];
    logic signed [ANG_W-1:0] z_reg    [STEPS];
    logic signed [ANG_W-1:0] z_next   [STEPS];

    always_comb
    begin
        logic signed [ANG_W-1:0] xs;
        logic signed [ANG_W-1:0] ys;
        logic signed [ANG_W-1:0] zs;
        logic signed [ANG_W-1:0] dx;
        logic signed [ANG_W-1:0] dy;
        logic signed [ANG_W-1:0] at;
        for (int i = 0; i < STEPS; i++)
        begin
            if (i == 0)
            begin
                xs = CORDIC_GAIN_Q30;
                ys = '0;
                zs = in_z;
            end
            else
            begin
                xs = x_reg[i-1];
                ys = y_reg[i-1];
                zs = z_reg[i-1];
            end
            dx = ys >>> i;
            dy = xs >>> i;
            at = $signed({2'b00, ATAN_Q30[i]});
            if (!zs[ANG_W-1])
            begin
                x_next[i] = xs - dx;
                y_next[i] = ys + dy;
                z_next[i] = zs - at;
            end
            else
            begin
                x_next[i] = xs + dx;
                y_next[i] = ys - dy;
                z_next[i] = zs + at;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < STEPS; i++)
            begin
                meta_reg[i] <= (i == 0) ? in_meta : meta_reg[i == 0 ? 0 : i-1];
                x_reg[i]    <= x_next[i];
                y_reg[i]    <= y_next[i];
                z_reg[i]    <= z_next[i];
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_meta  = meta_reg[STEPS-1];
    assign out_x     = x_reg[STEPS-1];
    assign out_y     = y_reg[STEPS-1];

endmodule
